FILE: hdl/modbus_sensor_frame_checker_defines.svh
// Assertion macros for the sensor frame checker.
`ifndef MODBUS_SENSOR_FRAME_CHECKER_DEFINES_SVH
`define MODBUS_SENSOR_FRAME_CHECKER_DEFINES_SVH

// prop must hold at every clock edge outside reset
`define MSFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// cond must never be seen at a clock edge outside reset
`define MSFC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/msfc_pkg.sv
// Shared types and constants of the sensor frame checker.
package msfc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int CO2_LIMIT = 10000;
	localparam int HT_LIMIT = 1000;
	localparam int CO2_FRAME_LEN = 7;
	localparam int HT_FRAME_LEN = 9;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		ST_OK,
		ST_CRC,
		ST_RANGE
	} status_t;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_CO2,
		KIND_HT
	} kind_t;

	// closed frame, front to back
	typedef struct packed {
		logic        crc_bad;
		kind_t       kind;
		logic [15:0] first_word;
		logic [15:0] second_word;
	} frame_t;

endpackage

FILE: hdl/msfc_front.sv
// Byte front end: CRC, length count, trailer and payload capture, frame close.
module msfc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic             push,
	output logic             full,
	output logic             q_push,
	output msfc_pkg::frame_t q_frame,
	input  logic             q_full
);

	localparam logic [7:0] CO2_LAST_IDX = 8'(msfc_pkg::CO2_FRAME_LEN - 1);
	localparam logic [7:0] HT_LAST_IDX  = 8'(msfc_pkg::HT_FRAME_LEN - 1);

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ msfc_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [15:0] crc_q, crc_n;
	logic [7:0]  count_q, count_n;
	logic [15:0] tail_q, tail_n;
	logic [31:0] pay_q, pay_n;
	logic        accept;

	assign full   = q_full;
	assign accept = push & ~q_full;
	assign q_push = accept & last_byte;

	always_comb begin
		crc_n   = (count_q >= 8'd2) ? crc_feed(crc_q, tail_q[15:8]) : crc_q;
		tail_n  = {tail_q[7:0], data_byte};
		pay_n   = pay_q;
		case (count_q)
			8'd3: pay_n[31:24] = data_byte;
			8'd4: pay_n[23:16] = data_byte;
			8'd5: pay_n[15:8]  = data_byte;
			8'd6: pay_n[7:0]   = data_byte;
			default: ;
		endcase
		count_n = (count_q == 8'hFF) ? count_q : count_q + 8'd1;

		if (count_q == CO2_LAST_IDX) begin
			q_frame.kind = msfc_pkg::KIND_CO2;
		end else if (count_q == HT_LAST_IDX) begin
			q_frame.kind = msfc_pkg::KIND_HT;
		end else begin
			q_frame.kind = msfc_pkg::KIND_OTHER;
		end
		// trailer is CRC low byte first
		q_frame.crc_bad     = (count_q == 8'd0) || (tail_n[15:8] == 8'h00) ||
			(tail_n[7:0] == 8'h00) || (crc_n != {tail_n[7:0], tail_n[15:8]});
		q_frame.first_word  = pay_n[31:16];
		q_frame.second_word = pay_n[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= msfc_pkg::CRC_INIT;
			count_q <= '0;
			tail_q  <= '0;
			pay_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				crc_q   <= msfc_pkg::CRC_INIT;
				count_q <= '0;
				tail_q  <= '0;
				pay_q   <= '0;
			end else begin
				crc_q   <= crc_n;
				count_q <= count_n;
				tail_q  <= tail_n;
				pay_q   <= pay_n;
			end
		end
	end

endmodule

FILE: hdl/msfc_queue.sv
// Short frame queue between front and back.
module msfc_queue #(
	parameter int DEPTH = msfc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  msfc_pkg::frame_t push_frame,
	output logic             q_full,
	input  logic             pop,
	output msfc_pkg::frame_t pop_frame,
	output logic             q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	msfc_pkg::frame_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign q_full    = (count_q == CNT_W'(DEPTH));
	assign q_empty   = (count_q == '0);
	assign do_push   = push & ~q_full;
	assign do_pop    = pop & ~q_empty;
	assign pop_frame = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/msfc_back.sv
// Back end: range check, value stores, BCD split pipeline, result register.
module msfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  msfc_pkg::frame_t q_frame,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       status,
	output logic [1:0]       frame_kind,
	output logic [13:0]      co2_value,
	output logic [15:0]      co2_bcd,
	output logic [9:0]       humidity_value,
	output logic [11:0]      humidity_bcd,
	output logic [9:0]       temperature_value,
	output logic [11:0]      temperature_bcd
);

	localparam logic [15:0] CO2_LIM = 16'(msfc_pkg::CO2_LIMIT);
	localparam logic [15:0] HT_LIM  = 16'(msfc_pkg::HT_LIMIT);

	typedef struct packed {
		msfc_pkg::status_t status;
		msfc_pkg::kind_t   kind;
		logic [13:0]       co2;
		logic [9:0]        hum;
		logic [9:0]        temp;
	} reading_t;

	typedef struct packed {
		logic [6:0] co2;
		logic [6:0] hum;
		logic [6:0] temp;
	} split_t;

	// v / 100 for v < 10000
	function automatic logic [6:0] div100(input logic [13:0] v);
		logic [26:0] p;
		p = 27'(v) * 27'd5243;
		return p[25:19];
	endfunction

	function automatic logic [6:0] rem100(input logic [13:0] v, input logic [6:0] q);
		logic [13:0] d;
		d = v - 14'(q) * 14'd100;
		return d[6:0];
	endfunction

	// two BCD digits of x < 100
	function automatic logic [7:0] bcd2(input logic [6:0] x);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  o;
		p = 15'(x) * 15'd205;
		t = p[14:11];
		o = x - 7'(t) * 7'd10;
		return {t, o[3:0]};
	endfunction

	logic [13:0] co2_q, co2_n;
	logic [9:0]  hum_q, hum_n;
	logic [9:0]  temp_q, temp_n;
	msfc_pkg::status_t st_n;

	reading_t rd_s1, rd_s2, rd_s3, rd_out_q;
	split_t   quo_s2, quo_s3, rem_s3;
	logic     v_s1, v_s2, v_s3, v_out_q;
	logic     rdy_s1, rdy_s2, rdy_s3, rdy_out;

	assign rdy_out = ~v_out_q | pop;
	assign rdy_s3  = ~v_s3 | rdy_out;
	assign rdy_s2  = ~v_s2 | rdy_s3;
	assign rdy_s1  = ~v_s1 | rdy_s2;
	assign q_pop   = ~q_empty & rdy_s1;
	assign empty   = ~v_out_q;

	always_comb begin
		st_n   = msfc_pkg::ST_OK;
		co2_n  = co2_q;
		hum_n  = hum_q;
		temp_n = temp_q;
		if (q_frame.crc_bad) begin
			st_n = msfc_pkg::ST_CRC;
		end else begin
			case (q_frame.kind)
				msfc_pkg::KIND_CO2: begin
					if (q_frame.first_word != 16'd0 && q_frame.first_word < CO2_LIM) begin
						co2_n = q_frame.first_word[13:0];
					end else begin
						st_n = msfc_pkg::ST_RANGE;
					end
				end
				msfc_pkg::KIND_HT: begin
					if (q_frame.first_word != 16'd0 && q_frame.first_word < HT_LIM) begin
						hum_n = q_frame.first_word[9:0];
						if (q_frame.second_word != 16'd0 && q_frame.second_word < HT_LIM) begin
							temp_n = q_frame.second_word[9:0];
						end else begin
							st_n = msfc_pkg::ST_RANGE;
						end
					end else begin
						st_n = msfc_pkg::ST_RANGE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			co2_q   <= '0;
			hum_q   <= '0;
			temp_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (q_pop) begin
				co2_q  <= co2_n;
				hum_q  <= hum_n;
				temp_q <= temp_n;
			end
			if (rdy_s1) begin
				v_s1 <= q_pop;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				v_out_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_s1 <= '{status: st_n, kind: q_frame.kind, co2: co2_n, hum: hum_n, temp: temp_n};
		end
		if (v_s1 && rdy_s2) begin
			rd_s2       <= rd_s1;
			quo_s2.co2  <= div100(rd_s1.co2);
			quo_s2.hum  <= div100(14'(rd_s1.hum));
			quo_s2.temp <= div100(14'(rd_s1.temp));
		end
		if (v_s2 && rdy_s3) begin
			rd_s3       <= rd_s2;
			quo_s3      <= quo_s2;
			rem_s3.co2  <= rem100(rd_s2.co2, quo_s2.co2);
			rem_s3.hum  <= rem100(14'(rd_s2.hum), quo_s2.hum);
			rem_s3.temp <= rem100(14'(rd_s2.temp), quo_s2.temp);
		end
		if (v_s3 && rdy_out) begin
			rd_out_q        <= rd_s3;
			co2_bcd         <= {bcd2(quo_s3.co2), bcd2(rem_s3.co2)};
			humidity_bcd    <= {quo_s3.hum[3:0], bcd2(rem_s3.hum)};
			temperature_bcd <= {quo_s3.temp[3:0], bcd2(rem_s3.temp)};
		end
	end

	assign status            = rd_out_q.status;
	assign frame_kind        = rd_out_q.kind;
	assign co2_value         = rd_out_q.co2;
	assign humidity_value    = rd_out_q.hum;
	assign temperature_value = rd_out_q.temp;

endmodule

FILE: hdl/modbus_sensor_frame_checker.sv
// Modbus sensor frame checker top level: CRC-16 check, value extraction and BCD split.
//
// Takes one frame byte per clock while full is low, with no gaps required: the front end
// feeds a byte into the CRC-16 (reflected 0xA001) when the second byte after it is
// accepted, so byte throughput is one beat per cycle. Only the last byte of a frame
// produces a result; closed frames wait in a QUEUE_DEPTH-entry queue, and the back end
// handles one frame per cycle, unless the result side stalls, through a four-register
// pipeline (range check and stores, divide by 100, remainder, BCD result register). full
// rises only when the queue is full, which needs the result side to be stalled. No
// clearing pass follows reset; the block takes bytes on the first cycle after it.
`include "modbus_sensor_frame_checker_defines.svh"

module modbus_sensor_frame_checker #(
	parameter int QUEUE_DEPTH = msfc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        push,
	output logic        full,
	output logic [1:0]  status,
	output logic [1:0]  frame_kind,
	output logic [13:0] co2_value,
	output logic [15:0] co2_bcd,
	output logic [9:0]  humidity_value,
	output logic [11:0] humidity_bcd,
	output logic [9:0]  temperature_value,
	output logic [11:0] temperature_bcd,
	output logic        empty,
	input  logic        pop
);

	msfc_pkg::frame_t push_frame, head_frame;
	logic             q_push, q_full, q_pop, q_empty;

	msfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push),
		.full      (full),
		.q_push    (q_push),
		.q_frame   (push_frame),
		.q_full    (q_full)
	);

	msfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_frame (push_frame),
		.q_full     (q_full),
		.pop        (q_pop),
		.pop_frame  (head_frame),
		.q_empty    (q_empty)
	);

	msfc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_frame           (head_frame),
		.q_empty           (q_empty),
		.q_pop             (q_pop),
		.empty             (empty),
		.pop               (pop),
		.status            (status),
		.frame_kind        (frame_kind),
		.co2_value         (co2_value),
		.co2_bcd           (co2_bcd),
		.humidity_value    (humidity_value),
		.humidity_bcd      (humidity_bcd),
		.temperature_value (temperature_value),
		.temperature_bcd   (temperature_bcd)
	);

	`MSFC_NEVER(a_queue_overflow, q_push && q_full, "frame pushed into full queue")
	`MSFC_NEVER(a_queue_underflow, q_pop && q_empty, "frame popped from empty queue")
	`MSFC_NEVER(a_status_code, !empty && status[1] && status[0], "undefined status code")
	`MSFC_NEVER(a_co2_range, !empty && (32'(co2_value) >= msfc_pkg::CO2_LIMIT), "co2 out of range")

endmodule
